>>> sv/qlu_pkg.sv
package qlu_pkg;

  localparam int MaxSideDef   = 16;
  localparam int ValueBitsDef = 24;
  localparam int FracBits     = 12;
  localparam int OneQ12       = 4096;
  // Working width of row, column and side arithmetic; holds any side up to 254 plus one.
  localparam int CoordW       = 8;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 24;

  localparam logic [1:0] OP_KIND   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_GOAL  = 2'd2;
  localparam logic [1:0] KIND_BODY  = 2'd3;

  localparam logic [1:0] ACT_UP    = 2'd0;
  localparam logic [1:0] ACT_RIGHT = 2'd1;
  localparam logic [1:0] ACT_DOWN  = 2'd2;
  localparam logic [1:0] ACT_LEFT  = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_GRID_SIDE      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEARN_RATE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DISCOUNT       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REWARD_GOAL    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REWARD_EMPTY   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REWARD_BLOCKED = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_PENALTY   = 3'd6;

  localparam logic [4:0]         RST_GRID_SIDE      = 5'd12;
  localparam logic [12:0]        RST_LEARN_RATE     = 13'd410;
  localparam logic [12:0]        RST_DISCOUNT       = 13'd3686;
  localparam logic signed [23:0] RST_REWARD_GOAL    = 24'sd4096;
  localparam logic signed [23:0] RST_REWARD_EMPTY   = -24'sd4096;
  localparam logic signed [23:0] RST_REWARD_BLOCKED = -24'sd40960;
  localparam logic signed [23:0] RST_EDGE_PENALTY   = -24'sd4091904;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] row;
    logic [3:0] col;
    logic [1:0] action;
    logic [1:0] kind;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] result_value;
    logic [1:0]         best_action;
  } out_word_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_MAX   = 6'b000100,
    S_MUL1  = 6'b001000,
    S_MUL2  = 6'b010000,
    S_WB    = 6'b100000
  } state_t;

endpackage

>>> sv/qlu_max4.sv
module qlu_max4 #(
  parameter int VALUE_BITS = qlu_pkg::ValueBitsDef
) (
  input  logic [4*VALUE_BITS-1:0]        row_vals,
  output logic signed [VALUE_BITS-1:0]   best_val,
  output logic [1:0]                     best_act
);
  import qlu_pkg::*;

  // Strict compare keeps the lowest action index on a tie.
  always_comb begin
    logic signed [VALUE_BITS-1:0] lane;
    best_val = signed'(row_vals[VALUE_BITS-1:0]);
    best_act = ACT_UP;
    for (int a = 1; a < 4; a++) begin
      lane = signed'(row_vals[a*VALUE_BITS +: VALUE_BITS]);
      if (lane > best_val) begin
        best_val = lane;
        best_act = 2'(a);
      end
    end
  end

endmodule

>>> sv/grid_q_learning_update.sv
// Grid Q-learning update block.
// Input channel (in_valid/in_ready/in_data) carries one operation per word: write a
// cell kind, apply one Q-learning update, or query the best action of a cell. Every
// accepted word produces exactly one result word on the output channel
// (out_valid/out_ready/out_data). The configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) is always ready and writes one register per word.
// The Q table holds one memory row per cell with all four action values, so an
// update reads the current and the next cell in the same cycle on two read ports.
// One word is in flight at a time. An accepted word is read into registers, then
// passes through S_MAX (max) and S_WB (write back); an in-range update whose next
// cell lies inside the grid also passes through S_MUL1 and S_MUL2 (two multiplies).
// The write back of one word always lands before the next word reads the table.
// After reset both memories are cleared by a pass over all MAX_SIDE*MAX_SIDE cells,
// one cell per cycle, while in_ready stays low; configuration is taken meanwhile.
// A stalled receiver holds the result in the output register; the block still takes
// the next word and holds its own result until the output register is free.
module grid_q_learning_update #(
  parameter int MAX_SIDE   = qlu_pkg::MaxSideDef,
  parameter int VALUE_BITS = qlu_pkg::ValueBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qlu_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qlu_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qlu_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [qlu_pkg::CfgDataW-1:0]  cfg_data
);
  import qlu_pkg::*;

  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int RW     = 4 * VALUE_BITS;
  localparam int WIDE   = (VALUE_BITS > 24) ? VALUE_BITS : 24;
  localparam int TW     = WIDE + 3;
  localparam int P1W    = VALUE_BITS + 14;
  localparam int P2W    = TW + 14;
  localparam int SW     = TW + 3;

  function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [SW-1:0] x);
    logic [SW-VALUE_BITS:0] upper;
    upper = x[SW-1:VALUE_BITS-1];
    if ((&upper) || (~|upper)) begin
      return x[VALUE_BITS-1:0];
    end else if (x[SW-1]) begin
      return {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  endfunction

  // Configuration registers.
  logic [4:0]         grid_side_r;
  logic [12:0]        learn_rate_r, discount_r;
  logic signed [23:0] reward_goal_r, reward_empty_r, reward_blocked_r, edge_penalty_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r      <= RST_GRID_SIDE;
      learn_rate_r     <= RST_LEARN_RATE;
      discount_r       <= RST_DISCOUNT;
      reward_goal_r    <= RST_REWARD_GOAL;
      reward_empty_r   <= RST_REWARD_EMPTY;
      reward_blocked_r <= RST_REWARD_BLOCKED;
      edge_penalty_r   <= RST_EDGE_PENALTY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_SIDE:      grid_side_r      <= cfg_data[4:0];
        CFG_LEARN_RATE:     learn_rate_r     <= cfg_data[12:0];
        CFG_DISCOUNT:       discount_r       <= cfg_data[12:0];
        CFG_REWARD_GOAL:    reward_goal_r    <= signed'(cfg_data);
        CFG_REWARD_EMPTY:   reward_empty_r   <= signed'(cfg_data);
        CFG_REWARD_BLOCKED: reward_blocked_r <= signed'(cfg_data);
        CFG_EDGE_PENALTY:   edge_penalty_r   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  logic [CoordW-1:0] side;
  logic [12:0]       lr_f, disc_f;

  always_comb begin
    if (grid_side_r < 5'd2) begin
      side = CoordW'(2);
    end else if (CoordW'(grid_side_r) > CoordW'(MAX_SIDE)) begin
      side = CoordW'(MAX_SIDE);
    end else begin
      side = CoordW'(grid_side_r);
    end
    lr_f   = (learn_rate_r > 13'(OneQ12)) ? 13'(OneQ12) : learn_rate_r;
    disc_f = (discount_r > 13'(OneQ12)) ? 13'(OneQ12) : discount_r;
  end

  // Address decode of the incoming word.
  logic [CoordW-1:0]   row_c, col_c, nr, nc;
  logic                in_range, next_ok;
  logic [2*CoordW-1:0] cur_full, nxt_full;
  logic [CELL_W-1:0]   cur_cell, nxt_cell;

  always_comb begin
    row_c = CoordW'(in_data.row);
    col_c = CoordW'(in_data.col);
    nr = row_c;
    nc = col_c;
    next_ok = 1'b0;
    unique case (in_data.action)
      ACT_UP: begin
        nr = row_c - 1'b1;
        next_ok = (row_c != '0);
      end
      ACT_RIGHT: begin
        nc = col_c + 1'b1;
        next_ok = (nc < side);
      end
      ACT_DOWN: begin
        nr = row_c + 1'b1;
        next_ok = (nr < side);
      end
      ACT_LEFT: begin
        nc = col_c - 1'b1;
        next_ok = (col_c != '0);
      end
      default: ;
    endcase
    in_range = (row_c < side) && (col_c < side);
    cur_full = (2*CoordW)'(row_c) * (2*CoordW)'(MAX_SIDE) + (2*CoordW)'(col_c);
    nxt_full = (2*CoordW)'(nr) * (2*CoordW)'(MAX_SIDE) + (2*CoordW)'(nc);
    cur_cell = cur_full[CELL_W-1:0];
    nxt_cell = nxt_full[CELL_W-1:0];
  end

  // Control.
  state_t            state_r, state_nxt;
  logic [CELL_W-1:0] clr_cnt_r;
  logic              out_valid_r;
  out_word_t         out_data_r;
  logic              rd_en, wb_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign rd_en     = in_valid && in_ready;
  assign wb_fire   = (state_r == S_WB) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Registered word fields.
  logic [1:0]        op_r, act_r, kind_r;
  logic [CELL_W-1:0] cell_r;
  logic              in_range_r, next_ok_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_r       <= in_data.opcode;
      act_r      <= in_data.action;
      kind_r     <= in_data.kind;
      cell_r     <= cur_cell;
      in_range_r <= in_range;
      next_ok_r  <= next_ok;
    end
  end

  // Memories: one row of four values per cell, and one kind per cell.
  logic [RW-1:0] q_mem [CELLS];
  logic [1:0]    kind_mem [CELLS];
  logic [RW-1:0] cur_row_r, nxt_row_r;
  logic [1:0]    nxt_kind_r;

  logic              q_we, k_we;
  logic [CELL_W-1:0] wr_addr;
  logic [RW-1:0]     q_wdata;
  logic [1:0]        k_wdata;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_row_r  <= q_mem[cur_cell];
      nxt_row_r  <= q_mem[nxt_cell];
      nxt_kind_r <= kind_mem[nxt_cell];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[wr_addr] <= q_wdata;
    end
    if (k_we) begin
      kind_mem[wr_addr] <= k_wdata;
    end
  end

  // Arithmetic chain.
  logic signed [VALUE_BITS-1:0] nmax_val, qbest_val;
  logic [1:0]                   nmax_act, qbest_act;

  qlu_max4 #(.VALUE_BITS(VALUE_BITS)) u_max_next (
    .row_vals (nxt_row_r),
    .best_val (nmax_val),
    .best_act (nmax_act)
  );

  qlu_max4 #(.VALUE_BITS(VALUE_BITS)) u_max_cur (
    .row_vals (cur_row_r),
    .best_val (qbest_val),
    .best_act (qbest_act)
  );

  logic signed [VALUE_BITS-1:0] m_r, qval_r, cur_r;
  logic [1:0]                   qact_r;
  logic signed [23:0]           reward_r;
  logic signed [P1W-1:0]        p1_r;
  logic signed [P2W-1:0]        p2_r;
  logic signed [TW-1:0]         t_val;
  logic signed [SW-1:0]         sum_val;
  logic signed [VALUE_BITS-1:0] upd_val;
  logic signed [23:0]           reward_sel;

  always_comb begin
    unique case (nxt_kind_r)
      KIND_GOAL:  reward_sel = reward_goal_r;
      KIND_EMPTY: reward_sel = reward_empty_r;
      default:    reward_sel = reward_blocked_r;
    endcase
  end

  // Products are floored by taking the bits above the fraction.
  assign t_val = TW'(reward_r) + TW'(signed'(p1_r[P1W-1:FracBits])) - TW'(cur_r);
  assign sum_val = SW'(cur_r) + SW'(signed'(p2_r[P2W-1:FracBits]));
  assign upd_val = next_ok_r ? sat_val(sum_val) : sat_val(SW'(edge_penalty_r));

  always_ff @(posedge clk) begin
    if (state_r == S_MAX) begin
      m_r      <= nmax_val;
      qval_r   <= qbest_val;
      qact_r   <= qbest_act;
      cur_r    <= signed'(cur_row_r[act_r*VALUE_BITS +: VALUE_BITS]);
      reward_r <= reward_sel;
    end
    if (state_r == S_MUL1) begin
      p1_r <= m_r * signed'({1'b0, disc_f});
    end
    if (state_r == S_MUL2) begin
      p2_r <= t_val * signed'({1'b0, lr_f});
    end
  end

  // Write port: clearing pass or write back.
  always_comb begin
    q_wdata = cur_row_r;
    for (int l = 0; l < 4; l++) begin
      if (2'(l) == act_r) begin
        q_wdata[l*VALUE_BITS +: VALUE_BITS] = upd_val;
      end
    end
    k_wdata = kind_r;
    wr_addr = cell_r;
    q_we    = wb_fire && in_range_r && (op_r == OP_UPDATE);
    k_we    = wb_fire && in_range_r && (op_r == OP_KIND);
    if (state_r == S_CLEAR) begin
      q_wdata = '0;
      k_wdata = KIND_EMPTY;
      wr_addr = clr_cnt_r;
      q_we    = 1'b1;
      k_we    = 1'b1;
    end
  end

  // Result word.
  out_word_t res_word;

  always_comb begin
    res_word.result_value = '0;
    res_word.best_action  = ACT_UP;
    if (in_range_r) begin
      unique case (op_r)
        OP_UPDATE: begin
          res_word.result_value = 24'(SW'(upd_val));
        end
        OP_QUERY: begin
          res_word.result_value = 24'(SW'(qval_r));
          res_word.best_action  = qact_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (rd_en) begin
          state_nxt = S_MAX;
        end
      end
      S_MAX: begin
        if ((op_r == OP_UPDATE) && in_range_r && next_ok_r) begin
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_WB;
      S_WB: begin
        if (wb_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (wb_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_data_r <= res_word;
    end
  end

endmodule

>>> tb/qlu_result_check.sv
`timescale 1ns / 100ps

module qlu_result_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  qlu_pkg::in_word_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  qlu_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [qlu_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [qlu_pkg::CfgDataW-1:0]  cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  import qlu_pkg::*;

  localparam int Side = MaxSideDef;

  logic signed [23:0] q_vals [Side*Side*4];
  logic [1:0]         cell_kind [Side*Side];

  logic [4:0]         side_reg;
  logic [12:0]        rate_reg;
  logic [12:0]        disc_reg;
  logic signed [23:0] goal_reg;
  logic signed [23:0] empty_reg;
  logic signed [23:0] blocked_reg;
  logic signed [23:0] edge_reg;

  out_word_t owed_results [$];

  function automatic logic signed [23:0] clip_value(input longint x);
    if (x > 64'sd8388607) return 24'sh7FFFFF;
    if (x < -64'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic logic signed [23:0] step_reward(input logic [1:0] k);
    if (k == KIND_GOAL) return goal_reg;
    if (k == KIND_EMPTY) return empty_reg;
    return blocked_reg;
  endfunction

  // Highest of the four values of a cell; the lowest action wins a tie.
  function automatic logic [1:0] best_move(input int spot, output logic signed [23:0] peak);
    logic [1:0] pick;
    int a;
    pick = ACT_UP;
    peak = q_vals[spot*4];
    for (a = 1; a < 4; a++) begin
      if (q_vals[spot*4+a] > peak) begin
        peak = q_vals[spot*4+a];
        pick = a[1:0];
      end
    end
    return pick;
  endfunction

  // Applies one operation to the shadow tables and returns the word it produces.
  function automatic out_word_t q_op_outcome(input in_word_t w);
    out_word_t          o;
    int                 side, nr, nc, spot, nxt, qi;
    longint             cur, rate, disc, target, upd;
    logic signed [23:0] peak;
    logic [1:0]         pick;
    o = '0;
    side = (side_reg < 5'd2) ? 2 : (side_reg > 5'd16) ? 16 : int'(side_reg);
    if (w.opcode != OP_NOP && int'(w.row) < side && int'(w.col) < side) begin
      spot = int'(w.row) * Side + int'(w.col);
      case (w.opcode)
        OP_KIND: begin
          cell_kind[spot] = w.kind;
        end
        OP_UPDATE: begin
          nr = int'(w.row);
          nc = int'(w.col);
          case (w.action)
            ACT_UP:    nr--;
            ACT_RIGHT: nc++;
            ACT_DOWN:  nr++;
            default:   nc--;
          endcase
          qi = spot * 4 + int'(w.action);
          if (nr < 0 || nc < 0 || nr >= side || nc >= side) begin
            o.result_value = edge_reg;
          end else begin
            nxt = nr * Side + nc;
            pick = best_move(nxt, peak);
            cur = q_vals[qi];
            rate = (rate_reg > 13'd4096) ? 64'sd4096 : longint'(rate_reg);
            disc = (disc_reg > 13'd4096) ? 64'sd4096 : longint'(disc_reg);
            target = longint'(step_reward(cell_kind[nxt])) + ((disc * peak) >>> FracBits) - cur;
            upd = cur + ((rate * target) >>> FracBits);
            o.result_value = clip_value(upd);
          end
          q_vals[qi] = o.result_value;
        end
        OP_QUERY: begin
          pick = best_move(spot, peak);
          o.best_action = pick;
          o.result_value = peak;
        end
        default: ;
      endcase
    end
    return o;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    out_word_t fresh;
    int        errs;
    int        i;
    errs = 0;
    if (!rst_n) begin
      for (i = 0; i < Side*Side*4; i++) q_vals[i] = '0;
      for (i = 0; i < Side*Side; i++) cell_kind[i] = KIND_EMPTY;
      side_reg    = RST_GRID_SIDE;
      rate_reg    = RST_LEARN_RATE;
      disc_reg    = RST_DISCOUNT;
      goal_reg    = RST_REWARD_GOAL;
      empty_reg   = RST_REWARD_EMPTY;
      blocked_reg = RST_REWARD_BLOCKED;
      edge_reg    = RST_EDGE_PENALTY;
      owed_results.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_SIDE:      side_reg    = cfg_data[4:0];
          CFG_LEARN_RATE:     rate_reg    = cfg_data[12:0];
          CFG_DISCOUNT:       disc_reg    = cfg_data[12:0];
          CFG_REWARD_GOAL:    goal_reg    = cfg_data;
          CFG_REWARD_EMPTY:   empty_reg   = cfg_data;
          CFG_REWARD_BLOCKED: blocked_reg = cfg_data;
          CFG_EDGE_PENALTY:   edge_reg    = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result word: value %0d action %0d",
                 out_data.result_value, out_data.best_action);
          errs++;
        end else begin
          want = owed_results.pop_front();
          if (out_data.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d",
                   want.result_value, out_data.result_value);
            errs++;
          end
          if (out_data.best_action !== want.best_action) begin
            $error("best_action: expected %0d, got %0d",
                   want.best_action, out_data.best_action);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh = q_op_outcome(in_data);
        owed_results = {owed_results, fresh};
      end
      mismatches  <= mismatches + errs;
      outstanding <= owed_results.size();
    end
  end

endmodule

>>> tb/tb_grid_q_learning_update.sv
`timescale 1ns / 100ps

module tb_grid_q_learning_update;
  import qlu_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;
  localparam int HoldCycles    = 400;
  localparam int ItemsPerPhase = 265;
  localparam int LimitNs       = 2_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_word_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_word_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int   fail_total;
  int   owed;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   side_now;
  logic hold_off_req;
  logic hold_off_done;

  grid_q_learning_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qlu_result_check u_result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (fail_total),
    .outstanding (owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LimitNs);
    $display("FAIL grid_q_learning_update");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request so the block backs up.
  initial begin
    out_ready     <= 1'b0;
    hold_off_done <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_off_done <= 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_word_t op_word(input logic [1:0] op, input logic [3:0] r,
                                       input logic [3:0] c, input logic [1:0] a,
                                       input logic [1:0] k);
    in_word_t w;
    w.opcode = op;
    w.row    = r;
    w.col    = c;
    w.action = a;
    w.kind   = k;
    return w;
  endfunction

  // Returns right after the accepting edge with valid still high.
  task automatic offer_word(input in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [23:0] side_w, input logic [23:0] rate_w,
                                input logic [23:0] disc_w, input logic [23:0] goal_w,
                                input logic [23:0] empty_w, input logic [23:0] blocked_w,
                                input logic [23:0] edge_w);
    set_reg(CFG_GRID_SIDE, side_w);
    set_reg(CFG_LEARN_RATE, rate_w);
    set_reg(CFG_DISCOUNT, disc_w);
    set_reg(CFG_REWARD_GOAL, goal_w);
    set_reg(CFG_REWARD_EMPTY, empty_w);
    set_reg(CFG_REWARD_BLOCKED, blocked_w);
    set_reg(CFG_EDGE_PENALTY, edge_w);
    cfg_valid <= 1'b0;
    side_now = (side_w[4:0] < 5'd2) ? 2 : (side_w[4:0] > 5'd16) ? 16 : int'(side_w[4:0]);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // Mostly well-formed operations inside the grid, with some noise around them.
  task automatic run_random(input int n);
    int         p;
    logic [1:0] op;
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 4) begin
        offer_word(op_word(OP_NOP, 4'($urandom_range(15)), 4'($urandom_range(15)),
                           2'($urandom_range(3)), 2'($urandom_range(3))));
      end else if (p < 9) begin
        offer_word(op_word(2'($urandom_range(2)), 4'($urandom_range(15)),
                           4'($urandom_range(15)), 2'($urandom_range(3)),
                           2'($urandom_range(3))));
      end else begin
        p  = $urandom_range(99);
        op = (p < 15) ? OP_KIND : (p < 78) ? OP_UPDATE : OP_QUERY;
        offer_word(op_word(op, 4'($urandom_range(side_now - 1)),
                           4'($urandom_range(side_now - 1)),
                           2'($urandom_range(3)), 2'($urandom_range(3))));
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    hold_off_req  <= 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 69;
    side_now      = 12;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset settings of a 12 by 12 grid.
    offer_word(op_word(OP_QUERY, 0, 0, ACT_UP, KIND_EMPTY));
    offer_word(op_word(OP_KIND, 0, 1, ACT_UP, KIND_GOAL));
    offer_word(op_word(OP_KIND, 1, 0, ACT_UP, KIND_WALL));
    offer_word(op_word(OP_KIND, 1, 1, ACT_UP, KIND_BODY));
    offer_word(op_word(OP_KIND, 11, 11, ACT_UP, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 0, 0, ACT_UP, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 0, 0, ACT_LEFT, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 11, 11, ACT_DOWN, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 11, 11, ACT_RIGHT, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 0, 0, ACT_RIGHT, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 0, 0, ACT_RIGHT, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 0, 0, ACT_DOWN, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 1, 0, ACT_RIGHT, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 2, 2, ACT_UP, KIND_EMPTY));
    offer_word(op_word(OP_UPDATE, 0, 1, ACT_LEFT, KIND_EMPTY));
    offer_word(op_word(OP_QUERY, 0, 0, ACT_UP, KIND_EMPTY));
    offer_word(op_word(OP_QUERY, 11, 11, ACT_UP, KIND_EMPTY));
    offer_word(op_word(OP_KIND, 12, 3, ACT_UP, KIND_WALL));
    offer_word(op_word(OP_UPDATE, 3, 12, ACT_RIGHT, KIND_EMPTY));
    offer_word(op_word(OP_QUERY, 15, 15, ACT_UP, KIND_EMPTY));
    offer_word(op_word(OP_NOP, 15, 15, ACT_LEFT, KIND_BODY));
    offer_word(op_word(OP_UPDATE, 1, 1, ACT_UP, KIND_EMPTY));
    drain_block();

    // Full grid, unit factors and extreme rewards drive the values into saturation.
    apply_settings(24'd16, 24'd4096, 24'd4096, 24'h7FFFFF, 24'h800000, 24'd0, 24'h7FFFFF);
    run_random(ItemsPerPhase);
    drain_block();

    apply_settings(24'd2, 24'd0, 24'd0, 24'd1, 24'hFFFFFF, 24'h800000, 24'h800000);
    run_random(ItemsPerPhase);
    drain_block();

    // Oversized side and factors are clamped; junk above the side field and a write
    // to an unused index must change nothing.
    send_idle_pct = 69;
    recv_idle_pct = 35;
    apply_settings(24'h5A5A5F, 24'd8191, 24'd5000, 24'($urandom), 24'($urandom),
                   24'($urandom), 24'($urandom));
    set_reg(CFG_UNUSED, 24'($urandom));
    cfg_valid <= 1'b0;
    run_random(ItemsPerPhase);
    drain_block();

    apply_settings(24'd0, 24'd4095, 24'd1, 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom));
    run_random(ItemsPerPhase);
    drain_block();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(24'd7, 24'($urandom_range(4096)), 24'($urandom_range(4096)),
                   24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    run_random(ItemsPerPhase);
    drain_block();

    apply_settings(24'd12, 24'd410, 24'd3686, 24'd4096, -24'sd4096, -24'sd40960,
                   -24'sd4091904);
    hold_off_req <= 1'b1;
    run_random(ItemsPerPhase);
    drain_block();

    repeat (10) @(posedge clk);
    if (fail_total == 0) begin
      $display("PASS grid_q_learning_update");
    end else begin
      $display("FAIL grid_q_learning_update");
    end
    $finish;
  end

endmodule
